// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked assertions, disabled while the active-low reset is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed");

`endif

// ===== hdl/cdq_pkg.sv =====
// ----------------------------------------------------------------------------
// Circular deque package
// Shared widths, operation and status codes, and controller command type.
// ----------------------------------------------------------------------------
package cdq_pkg;

  // Default number of storage slots.
  localparam int CDQ_DEPTH = 16;

  // Field widths.
  localparam int FUNC_W = 2;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;
  localparam int CAP_W  = 5;

  // Capacity after reset.
  localparam int CAP_RESET = 16;

  // Operation codes.
  localparam logic [FUNC_W-1:0] OP_PUSH_REAR  = 2'd0;
  localparam logic [FUNC_W-1:0] OP_PUSH_FRONT = 2'd1;
  localparam logic [FUNC_W-1:0] OP_POP_FRONT  = 2'd2;
  localparam logic [FUNC_W-1:0] OP_POP_REAR   = 2'd3;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;      // apply the accepted operation
    logic load_out;  // move the finished result into the output register
  } cdq_cmd_t;

endpackage

// ===== hdl/cdq_if.sv =====
// ----------------------------------------------------------------------------
// Circular deque channel interfaces
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------

// Request channel: one operation per beat.
interface cdq_in_if import cdq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [DATA_W-1:0] push_value;

  modport source (output valid, func, push_value, input ready);
  modport sink   (input valid, func, push_value, output ready);
endinterface

// Result channel: one result per beat.
interface cdq_out_if import cdq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic signed [DATA_W-1:0] popped_value;
  logic                     now_empty;
  logic                     now_full;

  modport source (output valid, status, popped_value, now_empty, now_full, input ready);
  modport sink   (input valid, status, popped_value, now_empty, now_full, output ready);
endinterface

// ===== hdl/cdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Circular deque controller
// Sequences one request through execute and result load, and owns out valid.
// ----------------------------------------------------------------------------
module cdq_ctrl import cdq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output cdq_cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LOAD = 1'b1;

  logic state_r;
  logic state_nxt;
  logic out_valid_r;
  logic out_valid_nxt;
  logic out_free;

  // The output register can take a new result when empty or being drained.
  assign out_free = !out_valid_r || out_ready;

  // Command decode.
  assign in_ready     = (state_r == ST_IDLE);
  assign cmd.exec     = in_valid && in_ready;
  assign cmd.load_out = (state_r == ST_LOAD) && out_free;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.exec) state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output valid: set on load, cleared when the beat is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== hdl/cdq_datapath.sv =====
// ----------------------------------------------------------------------------
// Circular deque datapath
// Slot memory, head and tail pointers, capacity, and the result registers.
// ----------------------------------------------------------------------------
module cdq_datapath import cdq_pkg::*; #(
  parameter int DEPTH = CDQ_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CAP_W-1:0]         cfg_wdata,
  input  cdq_cmd_t                 cmd,
  input  logic [FUNC_W-1:0]        func,
  input  logic signed [DATA_W-1:0] push_value,
  output logic [STAT_W-1:0]        status,
  output logic signed [DATA_W-1:0] popped_value,
  output logic                     now_empty,
  output logic                     now_full
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMP_W = ($clog2(DEPTH + 1) > CAP_W) ? $clog2(DEPTH + 1) : CAP_W;
  localparam int RST_CAP = (DEPTH < CAP_RESET) ? DEPTH : CAP_RESET;
  localparam logic [IDX_W-1:0] RST_LAST = IDX_W'(RST_CAP - 1);
  localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);
  localparam logic [CMP_W-1:0] DEPTH_C  = CMP_W'(DEPTH);

  logic signed [DATA_W-1:0] mem [DEPTH];

  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic             empty_r, empty_nxt;
  logic [IDX_W-1:0] cap_last_r;
  logic [IDX_W-1:0] cfg_last;
  logic [CMP_W-1:0] cfg_ext;

  logic [IDX_W-1:0] head_inc, head_dec, tail_inc, tail_dec, tail_nxt_inc;
  logic             full_now;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] rd_addr;
  logic             pop_ok;
  logic [STAT_W-1:0] stat;

  logic signed [DATA_W-1:0] rdata_r;
  logic                     pop_ok_r;
  logic [STAT_W-1:0]        stat_r;
  logic                     res_empty_r;
  logic                     res_full_r;

  logic [STAT_W-1:0]        out_status_r;
  logic signed [DATA_W-1:0] out_value_r;
  logic                     out_empty_r;
  logic                     out_full_r;

  // Last slot index for a capacity write: zero acts as one, large values clamp.
  always_comb begin
    cfg_ext = CMP_W'(cfg_wdata);
    priority if (cfg_ext == '0) begin
      cfg_last = '0;
    end else if (cfg_ext > DEPTH_C) begin
      cfg_last = IDX_W'(DEPTH - 1);
    end else begin
      cfg_last = IDX_W'(cfg_ext - CMP_W'(1));
    end
  end

  // Pointer neighbors, wrapping at the capacity in use.
  assign head_inc = (head_r == cap_last_r) ? '0 : head_r + IDX_ONE;
  assign head_dec = (head_r == '0) ? cap_last_r : head_r - IDX_ONE;
  assign tail_inc = (tail_r == cap_last_r) ? '0 : tail_r + IDX_ONE;
  assign tail_dec = (tail_r == '0) ? cap_last_r : tail_r - IDX_ONE;
  assign full_now = !empty_r && (tail_inc == head_r);

  // Operation decode and next pointer state.
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    empty_nxt = empty_r;
    wr_en     = 1'b0;
    wr_addr   = '0;
    rd_addr   = head_r;
    pop_ok    = 1'b0;
    stat      = ST_DONE;
    unique case (func)
      OP_PUSH_REAR, OP_PUSH_FRONT: begin
        priority if (full_now) begin
          stat = ST_FULL;
        end else if (empty_r) begin
          head_nxt  = '0;
          tail_nxt  = '0;
          empty_nxt = 1'b0;
          wr_en     = 1'b1;
          wr_addr   = '0;
        end else if (func == OP_PUSH_REAR) begin
          tail_nxt = tail_inc;
          wr_en    = 1'b1;
          wr_addr  = tail_inc;
        end else begin
          head_nxt = head_dec;
          wr_en    = 1'b1;
          wr_addr  = head_dec;
        end
      end
      OP_POP_FRONT, OP_POP_REAR: begin
        priority if (empty_r) begin
          stat = ST_EMPTY;
        end else begin
          pop_ok  = 1'b1;
          rd_addr = (func == OP_POP_FRONT) ? head_r : tail_r;
          priority if (head_r == tail_r) begin
            head_nxt  = '0;
            tail_nxt  = '0;
            empty_nxt = 1'b1;
          end else if (func == OP_POP_FRONT) begin
            head_nxt = head_inc;
          end else begin
            tail_nxt = tail_dec;
          end
        end
      end
      default: stat = ST_DONE;
    endcase
  end

  // Full flag as it stands after the operation.
  assign tail_nxt_inc = (tail_nxt == cap_last_r) ? '0 : tail_nxt + IDX_ONE;

  // Pointer and capacity registers; a capacity write empties the deque.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      tail_r     <= '0;
      empty_r    <= 1'b1;
      cap_last_r <= RST_LAST;
    end else if (cfg_we) begin
      head_r     <= '0;
      tail_r     <= '0;
      empty_r    <= 1'b1;
      cap_last_r <= cfg_last;
    end else if (cmd.exec) begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      empty_r <= empty_nxt;
    end
  end

  // Slot memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      mem[wr_addr] <= push_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // Result stage, captured while the operation executes.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      pop_ok_r    <= pop_ok;
      stat_r      <= stat;
      res_empty_r <= empty_nxt;
      res_full_r  <= !empty_nxt && (tail_nxt_inc == head_nxt);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r <= stat_r;
      out_value_r  <= pop_ok_r ? rdata_r : '0;
      out_empty_r  <= res_empty_r;
      out_full_r   <= res_full_r;
    end
  end

  assign status       = out_status_r;
  assign popped_value = out_value_r;
  assign now_empty    = out_empty_r;
  assign now_full     = out_full_r;

endmodule

// ===== hdl/circular_double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// Circular double-ended queue
// Deque of signed 32-bit values in a circular slot memory, pushed and popped
// at either end, with a run-time capacity register.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one request per beat: func selects push rear, push front,
//   pop front or pop rear, and push_value is the value a push stores.
//   out_ch returns one result beat per request, in order: status, the popped
//   value (zero unless a pop succeeded), and the empty and full flags after
//   the operation. A push into a full deque or a pop from an empty one
//   reports its status and changes nothing.
//   cfg_we/cfg_wdata set the capacity (zero acts as one, values above DEPTH
//   act as DEPTH) and empty the deque; write it only while no request is open.
//   A request's result is captured in the result registers as the request is
//   accepted, then moved into the output register once that register is free.
//   No new request is accepted until the last result has been moved there.
//   The output register holds a finished result while out_ch is stalled; a
//   new request is still accepted, and its result waits until the held beat
//   is taken. Reset empties the deque and sets the capacity to 16, or DEPTH
//   if that is smaller. No clearing pass is needed: slots are read only
//   after they have been written.
// ----------------------------------------------------------------------------
module circular_double_ended_queue import cdq_pkg::*; #(
  parameter int DEPTH = CDQ_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata,
  cdq_in_if.sink           in_ch,
  cdq_out_if.source        out_ch
);

  cdq_cmd_t cmd;

  // Sequencing and handshakes.
  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // Storage, pointers and result registers.
  cdq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .cmd          (cmd),
    .func         (in_ch.func),
    .push_value   (in_ch.push_value),
    .status       (out_ch.status),
    .popped_value (out_ch.popped_value),
    .now_empty    (out_ch.now_empty),
    .now_full     (out_ch.now_full)
  );

endmodule

// ===== hdl/cdq_checker.sv =====
// ----------------------------------------------------------------------------
// Circular deque checker
// Port-level assertions on handshakes and result consistency.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cdq_checker import cdq_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [STAT_W-1:0]        status,
  input logic signed [DATA_W-1:0] popped_value,
  input logic                     now_empty,
  input logic                     now_full
);

  // A stalled result beat keeps its payload.
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(popped_value) && $stable(status))

  // The block works on one request at a time.
  `ASSERT_NEXT(a_one_open, clk, rst_n, in_valid && in_ready, !in_ready)

  // A rejected push leaves a full deque behind.
  `ASSERT_SAME(a_full_reject, clk, rst_n, out_valid && (status == ST_FULL), now_full && !now_empty)

  // A rejected operation returns a zero value.
  `ASSERT_SAME(a_zero_value, clk, rst_n, out_valid && (status != ST_DONE), popped_value == '0)

  // Empty and full never hold together on a valid result beat.
  `ASSERT_NEVER(a_flags, clk, rst_n, out_valid && now_empty && now_full)

endmodule

bind circular_double_ended_queue cdq_checker u_cdq_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .status       (out_ch.status),
  .popped_value (out_ch.popped_value),
  .now_empty    (out_ch.now_empty),
  .now_full     (out_ch.now_full)
);
